### rtl/ekrp_pkg.sv
// Shared types and constants of the board-info record parser.
package ekrp_pkg;

  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_EA   = 3'd1,
    KEY_SB   = 3'd2,
    KEY_D1   = 3'd3,
    KEY_HZ   = 3'd4
  } key_e;

  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] CharFill    = 8'hff;
  localparam logic [7:0] CharNull    = 8'h00;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharSlash   = 8'h2f;

  localparam logic [31:0] BaudScale  = 32'd100;
  localparam logic [31:0] MemScale   = 32'd1048576;
  localparam logic [31:0] FreqScale  = 32'd1000000;
  localparam logic [31:0] BusLimit   = 32'd50;

  localparam int unsigned DivSteps   = 32;
  localparam int unsigned OutWidth   = 184;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // take the accepted byte
    logic div_step;  // one remainder iteration
    logic rnd;       // round the pending value down
    logic mul;       // scale the rounded value
    logic save;      // store the scaled value
    logic load_out;  // copy the result into the output register
  } ekrp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic commit_req;  // a known record waits to be stored
    logic div_nz;      // the pending record carries a nonzero rounding digit
    logic emit_req;    // a result is due once the store finishes
    logic out_free;    // the output register can take a result
  } ekrp_sts_t;

endpackage

### rtl/eeprom_key_record_parser.sv
// Top level of the board-info key record parser.
//
//   Channel  Dir  Handshake             Payload
//   s_axis   in   tvalid/tready         tdata: data_byte; tuser: first; tlast: last
//   m_axis   out  tvalid/tready         tdata: mac, baud, memory, core, bus, mask, clean
//
// A byte is accepted in S_IDLE, then the sequencer checks it in S_EVAL before the next is taken.
// A byte that closes an SB, D1 or HZ record adds the rounding, scaling and store steps;
// an HZ record with a nonzero rounding digit first runs the bit-serial remainder unit.
// A byte that produces a result then loads the output register.
// Reset clears all parse state and the output valid; no clearing pass is needed.
// A result waits in the output register while new bytes are taken; a second result
// holds the sequencer until the first one is taken.
module eeprom_key_record_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte[7:0]
  input  logic         s_axis_tuser_i,   // first
  input  logic         s_axis_tlast_i,   // last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // mac_address[47:0], baud_rate[79:48], memory_bytes[111:80], core_freq_hz[143:112],
  // bus_freq_hz[175:144], found_mask[179:176], ended_clean[180], zero fill[183:181]
  output logic [ekrp_pkg::OutWidth-1:0] m_axis_tdata_o
);

  ekrp_pkg::ekrp_cmd_t cmd;
  ekrp_pkg::ekrp_sts_t sts;

  ekrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ekrp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (s_axis_tdata_i),
    .first_i     (s_axis_tuser_i),
    .last_i      (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### rtl/ekrp_ctrl.sv
// Sequencer for byte intake, record store and result output.
module ekrp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ekrp_pkg::ekrp_sts_t sts_i,
  output ekrp_pkg::ekrp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_RND,
    S_MUL,
    S_SAVE,
    S_EMIT
  } state_e;

  localparam int unsigned CntW = $clog2(ekrp_pkg::DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(ekrp_pkg::DivSteps - 1);

  state_e state_q;
  logic [CntW-1:0] cnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.step     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.rnd      = (state_q == S_RND);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.save     = (state_q == S_SAVE);
    cmd_o.load_out = (state_q == S_EMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          cnt_q <= '0;
          if (sts_i.commit_req) begin
            state_q <= sts_i.div_nz ? S_DIV : S_RND;
          end else if (sts_i.emit_req) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= S_RND;
        end
        S_RND: state_q <= S_MUL;
        S_MUL: state_q <= S_SAVE;
        S_SAVE: begin
          state_q <= sts_i.emit_req ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ekrp_dpath.sv
// Parse state, record store arithmetic and output register.
module ekrp_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  logic                first_i,
  input  logic                last_i,
  input  ekrp_pkg::ekrp_cmd_t cmd_i,
  output ekrp_pkg::ekrp_sts_t sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ekrp_pkg::OutWidth-1:0] out_data_o
);

  // Record parse state.
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  fk_q, fk_d;
  ekrp_pkg::key_e key_q, key_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  pb_q, pb_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  ph_q, ph_d;
  logic [7:0]  rdiv_q, rdiv_d;
  logic [3:0]  mask_q, mask_d;
  logic        at_q, at_d;
  logic        td_q, td_d;

  // Stored record values.
  logic [31:0] baud_q, mem_q, core_q, bus_q;

  // Pending store and result.
  ekrp_pkg::key_e pkey_q, pkey_d;
  logic [31:0] pnum_q, pnum_d;
  logic [7:0]  pdiv_q, pdiv_d;
  logic        emit_q, emit_d;
  logic        clean_q, clean_d;

  // Remainder unit and scaling.
  logic [31:0] shr_q;
  logic [7:0]  rem_q;
  logic [8:0]  rem_try;
  logic [31:0] rnd_q;
  logic [31:0] prod_q;
  logic        gt50_q;
  logic [31:0] scale;
  logic [31:0] prod_full;

  logic        out_valid_q;
  logic [ekrp_pkg::OutWidth-1:0] out_q;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else v = c - ekrp_pkg::CharZero;
    return v;
  endfunction

  function automatic logic [31:0] dec_next(input logic [31:0] a, input logic [7:0] c);
    return {a[28:0], 3'b000} + {a[30:0], 1'b0} + {24'd0, c}
           - {24'd0, ekrp_pkg::CharZero};
  endfunction

  always_comb begin
    logic        term;
    logic [7:0]  hv;
    logic [7:0]  bval;
    logic [2:0]  bidx;
    pos_d   = pos_q;   fk_d  = fk_q;   key_d  = key_q;  nib_d = nib_q;
    pb_d    = pb_q;    mac_d = mac_q;  acc_d  = acc_q;  ph_d  = ph_q;
    rdiv_d  = rdiv_q;  mask_d = mask_q; at_d  = at_q;   td_d  = td_q;
    pkey_d  = ekrp_pkg::KEY_NONE;
    pnum_d  = acc_q;
    pdiv_d  = rdiv_q;
    emit_d  = 1'b0;
    clean_d = 1'b0;
    term    = (data_byte_i == ekrp_pkg::CharNewline) || (data_byte_i == ekrp_pkg::CharFill);
    hv      = hex_value(data_byte_i);
    bval    = 8'd0;
    bidx    = nib_q[3:1];

    if (first_i) begin
      pos_d = '0; fk_d = '0; key_d = ekrp_pkg::KEY_NONE; nib_d = '0; pb_d = '0;
      mac_d = '0; acc_d = '0; ph_d = '0; rdiv_d = '0; mask_d = '0;
      at_d = 1'b0; td_d = 1'b0;
    end

    if (!td_d) begin
      if (at_d) begin
        at_d = 1'b0;
        if (data_byte_i == ekrp_pkg::CharNull || data_byte_i == ekrp_pkg::CharFill) begin
          td_d    = 1'b1;
          emit_d  = 1'b1;
          clean_d = 1'b1;
        end
      end
    end

    if (!td_d) begin
      if (term) begin
        pkey_d = key_d;
        pnum_d = acc_d;
        pdiv_d = rdiv_d;
        pos_d = '0; fk_d = '0; key_d = ekrp_pkg::KEY_NONE; nib_d = '0; pb_d = '0;
        acc_d = '0; ph_d = '0; rdiv_d = '0;
        at_d  = 1'b1;
      end else begin
        case (pos_d)
          2'd0: begin
            fk_d  = data_byte_i;
            pos_d = 2'd1;
          end
          2'd1: begin
            if (fk_d == 8'h45 && data_byte_i == 8'h41) begin
              key_d = ekrp_pkg::KEY_EA;
              mac_d = '0;
              mask_d[0] = 1'b1;
            end else if (fk_d == 8'h53 && data_byte_i == 8'h42) begin
              key_d = ekrp_pkg::KEY_SB;
              mask_d[1] = 1'b1;
            end else if (fk_d == 8'h44 && data_byte_i == 8'h31) begin
              key_d = ekrp_pkg::KEY_D1;
              mask_d[2] = 1'b1;
            end else if (fk_d == 8'h48 && data_byte_i == 8'h5a) begin
              key_d = ekrp_pkg::KEY_HZ;
              mask_d[3] = 1'b1;
            end
            pos_d = 2'd2;
          end
          2'd2: pos_d = 2'd3;
          default: begin
            case (key_d)
              ekrp_pkg::KEY_EA: begin
                if (nib_d < 4'd12) begin
                  bidx = nib_d[3:1];
                  if (!nib_d[0]) begin
                    pb_d = {hv[3:0], 4'd0};
                    bval = {hv[3:0], 4'd0};
                  end else begin
                    bval = pb_d + hv;
                  end
                  for (int i = 0; i < 6; i++) begin
                    if (bidx == 3'(i)) mac_d[47-8*i -: 8] = bval;
                  end
                  nib_d = nib_d + 4'd1;
                end
              end
              ekrp_pkg::KEY_SB, ekrp_pkg::KEY_D1: begin
                acc_d = dec_next(acc_d, data_byte_i);
              end
              ekrp_pkg::KEY_HZ: begin
                case (ph_d)
                  2'd0: begin
                    acc_d = dec_next(acc_d, data_byte_i);
                    ph_d  = 2'd1;
                  end
                  2'd1: begin
                    if (data_byte_i == ekrp_pkg::CharSlash) ph_d = 2'd2;
                    else acc_d = dec_next(acc_d, data_byte_i);
                  end
                  2'd2: begin
                    rdiv_d = data_byte_i - ekrp_pkg::CharZero;
                    ph_d   = 2'd3;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        endcase
      end
    end

    // A record still open at the buffer's end is stored as if terminated.
    if (last_i && !td_d) begin
      if (!at_d) begin
        pkey_d = key_d;
        pnum_d = acc_d;
        pdiv_d = rdiv_d;
      end
      td_d    = 1'b1;
      emit_d  = 1'b1;
      clean_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fk_q   <= '0;
      key_q  <= ekrp_pkg::KEY_NONE;
      nib_q  <= '0;
      pb_q   <= '0;
      mac_q  <= '0;
      acc_q  <= '0;
      ph_q   <= '0;
      rdiv_q <= '0;
      mask_q <= '0;
      at_q   <= 1'b0;
      td_q   <= 1'b0;
      pkey_q <= ekrp_pkg::KEY_NONE;
      emit_q <= 1'b0;
      baud_q <= '0;
      mem_q  <= '0;
      core_q <= '0;
      bus_q  <= '0;
    end else begin
      if (cmd_i.step) begin
        pos_q  <= pos_d;
        fk_q   <= fk_d;
        key_q  <= key_d;
        nib_q  <= nib_d;
        pb_q   <= pb_d;
        mac_q  <= mac_d;
        acc_q  <= acc_d;
        ph_q   <= ph_d;
        rdiv_q <= rdiv_d;
        mask_q <= mask_d;
        at_q   <= at_d;
        td_q   <= td_d;
        pkey_q <= pkey_d;
        emit_q <= emit_d;
        if (first_i) begin
          baud_q <= '0;
          mem_q  <= '0;
          core_q <= '0;
          bus_q  <= '0;
        end
      end
      if (cmd_i.save) begin
        case (pkey_q)
          ekrp_pkg::KEY_SB: baud_q <= prod_q;
          ekrp_pkg::KEY_D1: mem_q  <= prod_q;
          ekrp_pkg::KEY_HZ: begin
            core_q <= prod_q;
            bus_q  <= gt50_q ? {1'b0, prod_q[31:1]} : prod_q;
          end
          default: ;
        endcase
      end
    end
  end

  // Restoring remainder: one dividend bit per iteration, most significant first.
  assign rem_try = {rem_q, shr_q[31]};

  always_comb begin
    case (pkey_q)
      ekrp_pkg::KEY_SB: scale = ekrp_pkg::BaudScale;
      ekrp_pkg::KEY_D1: scale = ekrp_pkg::MemScale;
      default:          scale = ekrp_pkg::FreqScale;
    endcase
  end

  // Only the low word of the product is kept, so the scaled value wraps at 32 bits.
  assign prod_full = rnd_q * scale;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pnum_q  <= pnum_d;
      pdiv_q  <= pdiv_d;
      clean_q <= clean_d;
      shr_q   <= pnum_d;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      shr_q <= {shr_q[30:0], 1'b0};
      if (rem_try >= {1'b0, pdiv_q}) rem_q <= 8'(rem_try - {1'b0, pdiv_q});
      else rem_q <= rem_try[7:0];
    end
    if (cmd_i.rnd) rnd_q <= pnum_q - {24'd0, rem_q};
    if (cmd_i.mul) begin
      prod_q <= prod_full;
      gt50_q <= (rnd_q > ekrp_pkg::BusLimit);
    end
    if (cmd_i.load_out) begin
      out_q <= {3'd0, clean_q, mask_q, bus_q, core_q, mem_q, baud_q, mac_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.commit_req = (pkey_q == ekrp_pkg::KEY_SB) || (pkey_q == ekrp_pkg::KEY_D1) ||
                            (pkey_q == ekrp_pkg::KEY_HZ);
  assign sts_o.div_nz     = (pkey_q == ekrp_pkg::KEY_HZ) && (pdiv_q != 8'd0);
  assign sts_o.emit_req   = emit_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/tb_eeprom_key_record_parser.sv
// Self-checking testbench for the board-info key record parser.
`timescale 1ns / 100ps

module tb_eeprom_key_record_parser;

  localparam int unsigned CycleLimit    = 400000;
  localparam int          DrainCycles   = 64;
  localparam int          RandomBytes   = 370;
  localparam int          LongHold      = 400;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] baud;
    logic [31:0] mem;
    logic [31:0] core;
    logic [31:0] bus;
    logic [3:0]  mask;
    logic        clean;
  } board_info_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                src_valid = 1'b0;
  logic                src_ready;
  logic [7:0]          src_data  = 8'h00;
  logic                src_first = 1'b0;
  logic                src_last  = 1'b0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [ekrp_pkg::OutWidth-1:0] res_data;

  int unsigned cycle_cnt         = 0;
  int          err_cnt           = 0;
  int          results_predicted = 0;
  bit          src_random        = 1'b1;
  bit          sink_random       = 1'b1;
  int          sink_stall        = 0;
  int          sink_hold_req     = 0;

  board_info_t board_info_q[$];
  logic [7:0]  frame_q[$];

  // Parser state as seen by the predictor.
  logic [1:0]  rec_pos;
  logic [7:0]  key_ch;
  ekrp_pkg::key_e cur_key;
  logic [3:0]  nib_cnt;
  logic [7:0]  partial;
  logic [47:0] mac_acc;
  logic [31:0] dec_acc;
  logic [1:0]  hz_phase;
  logic [7:0]  round_div;
  logic [31:0] baud_v, mem_v, core_v, bus_v;
  logic [3:0]  seen;
  logic        after_term;
  logic        tbl_done;

  eeprom_key_record_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_data),
    .s_axis_tuser_i  (src_first),
    .s_axis_tlast_i  (src_last),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  task automatic restart_record();
    rec_pos   = 2'd0;
    key_ch    = 8'h00;
    cur_key   = ekrp_pkg::KEY_NONE;
    nib_cnt   = 4'd0;
    partial   = 8'h00;
    dec_acc   = 32'd0;
    hz_phase  = 2'd0;
    round_div = 8'h00;
  endtask

  task automatic clear_parse_state();
    restart_record();
    mac_acc    = '0;
    baud_v     = 32'd0;
    mem_v      = 32'd0;
    core_v     = 32'd0;
    bus_v      = 32'd0;
    seen       = 4'd0;
    after_term = 1'b0;
    tbl_done   = 1'b0;
  endtask

  function automatic logic [31:0] dec_step(input logic [31:0] acc, input logic [7:0] c);
    return acc * 32'd10 + ({24'd0, c} - {24'd0, ekrp_pkg::CharZero});
  endfunction

  task automatic put_mac_byte(input logic [2:0] idx, input logic [7:0] val);
    mac_acc[47 - 8 * idx -: 8] = val;
  endtask

  task automatic commit_record_value();
    logic [31:0] num;
    num = dec_acc;
    case (cur_key)
      ekrp_pkg::KEY_SB: baud_v = num * ekrp_pkg::BaudScale;
      ekrp_pkg::KEY_D1: mem_v = num * ekrp_pkg::MemScale;
      ekrp_pkg::KEY_HZ: begin
        if (round_div != 8'h00) num = (num / round_div) * round_div;
        core_v = num * ekrp_pkg::FreqScale;
        bus_v  = (num > ekrp_pkg::BusLimit) ? (core_v >> 1) : core_v;
      end
      default: ;
    endcase
  endtask

  task automatic predict_board_byte(input logic [7:0] c, input logic is_first,
                                    input logic is_last);
    logic        emit;
    logic        clean;
    logic [7:0]  nib;
    board_info_t r;
    emit  = 1'b0;
    clean = 1'b0;
    if (is_first) clear_parse_state();
    if (!tbl_done) begin
      // Only the byte right after a terminator can close the table cleanly.
      if (after_term) begin
        after_term = 1'b0;
        if (c == ekrp_pkg::CharNull || c == ekrp_pkg::CharFill) begin
          tbl_done = 1'b1;
          emit     = 1'b1;
          clean    = 1'b1;
        end
      end
      if (!tbl_done) begin
        if (c == ekrp_pkg::CharNewline || c == ekrp_pkg::CharFill) begin
          commit_record_value();
          restart_record();
          after_term = 1'b1;
        end else begin
          case (rec_pos)
            2'd0: begin
              key_ch  = c;
              rec_pos = 2'd1;
            end
            2'd1: begin
              if (key_ch == "E" && c == "A") begin
                cur_key = ekrp_pkg::KEY_EA;
                mac_acc = '0;
                seen[0] = 1'b1;
              end else if (key_ch == "S" && c == "B") begin
                cur_key = ekrp_pkg::KEY_SB;
                seen[1] = 1'b1;
              end else if (key_ch == "D" && c == "1") begin
                cur_key = ekrp_pkg::KEY_D1;
                seen[2] = 1'b1;
              end else if (key_ch == "H" && c == "Z") begin
                cur_key = ekrp_pkg::KEY_HZ;
                seen[3] = 1'b1;
              end
              rec_pos = 2'd2;
            end
            2'd2: rec_pos = 2'd3;
            default: begin
              case (cur_key)
                ekrp_pkg::KEY_EA: begin
                  if (nib_cnt < 4'd12) begin
                    if (c >= "A" && c <= "F") nib = c - "A" + 8'd10;
                    else if (c >= "a" && c <= "f") nib = c - "a" + 8'd10;
                    else nib = c - ekrp_pkg::CharZero;
                    if (!nib_cnt[0]) begin
                      partial = {nib[3:0], 4'h0};
                      put_mac_byte(nib_cnt[3:1], partial);
                    end else begin
                      put_mac_byte(nib_cnt[3:1], partial + nib);
                    end
                    nib_cnt = nib_cnt + 4'd1;
                  end
                end
                ekrp_pkg::KEY_SB, ekrp_pkg::KEY_D1: dec_acc = dec_step(dec_acc, c);
                ekrp_pkg::KEY_HZ: begin
                  case (hz_phase)
                    2'd0: begin
                      dec_acc  = dec_step(dec_acc, c);
                      hz_phase = 2'd1;
                    end
                    2'd1: begin
                      if (c == ekrp_pkg::CharSlash) hz_phase = 2'd2;
                      else dec_acc = dec_step(dec_acc, c);
                    end
                    2'd2: begin
                      round_div = c - ekrp_pkg::CharZero;
                      hz_phase  = 2'd3;
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
          endcase
        end
      end
      if (is_last && !tbl_done) begin
        if (!after_term) commit_record_value();
        tbl_done = 1'b1;
        emit     = 1'b1;
        clean    = 1'b0;
      end
      if (emit) begin
        r.mac   = mac_acc;
        r.baud  = baud_v;
        r.mem   = mem_v;
        r.core  = core_v;
        r.bus   = bus_v;
        r.mask  = seen;
        r.clean = clean;
        board_info_q.push_back(r);
        results_predicted++;
      end
    end
  endtask

  // ----------------------------------------------------------- result checker

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    board_info_t want;
    if (rst_n && res_valid && res_ready) begin
      if (board_info_q.size() == 0) begin
        $error("result with no request pending: 0x%0h", res_data);
        err_cnt++;
      end else begin
        want = board_info_q.pop_front();
        check_field("mac_address",  want.mac, res_data[47:0]);
        check_field("baud_rate",    48'(want.baud), 48'(res_data[79:48]));
        check_field("memory_bytes", 48'(want.mem), 48'(res_data[111:80]));
        check_field("core_freq_hz", 48'(want.core), 48'(res_data[143:112]));
        check_field("bus_freq_hz",  48'(want.bus), 48'(res_data[175:144]));
        check_field("found_mask",   48'(want.mask), 48'(res_data[179:176]));
        check_field("ended_clean",  48'(want.clean), 48'(res_data[180]));
      end
      sink_stall = sink_random ? $urandom_range(0, 4) : 0;
    end
  end

  // The receiver keeps its own count of stall cycles; a test may ask for a long hold.
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        sink_stall    = sink_hold_req;
        sink_hold_req = 0;
      end
      if (sink_stall > 0) begin
        res_ready <= 1'b0;
        sink_stall--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    int gap;
    gap = src_random ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_data  <= b;
    src_first <= is_first;
    src_last  <= is_last;
    do @(posedge clk); while (!src_ready);
    predict_board_byte(b, is_first, is_last);
  endtask

  task automatic send_frame(input bit with_first, input bit with_last);
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], with_first && i == 0, with_last && i == frame_q.size() - 1);
  endtask

  // Drops the request and waits until every predicted result has been taken.
  task automatic wait_results_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (board_info_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ekrp_pkg::CharNewline || b == ekrp_pkg::CharFill) b = ekrp_pkg::CharSlash;
    return b;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(ekrp_pkg::CharZero + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] dec_char();
    return ($urandom_range(0, 7) == 0) ? plain_byte() : digit_char();
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 9))
      5, 6:    return 8'("A" + $urandom_range(0, 5));
      7, 8:    return 8'("a" + $urandom_range(0, 5));
      9:       return plain_byte();
      default: return digit_char();
    endcase
  endfunction

  task automatic add_random_record();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        add_str("EA");
        frame_q.push_back(plain_byte());
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 12;
        repeat (n) frame_q.push_back(hex_char());
      end
      2, 3, 10: begin
        if ($urandom_range(0, 1) != 0) add_str("SB");
        else add_str("D1");
        frame_q.push_back(plain_byte());
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
        repeat (n) frame_q.push_back(dec_char());
      end
      4, 5, 11: begin
        add_str("HZ");
        frame_q.push_back(plain_byte());
        if ($urandom_range(0, 7) == 0) frame_q.push_back(ekrp_pkg::CharSlash);
        n = $urandom_range(0, 3);
        repeat (n) frame_q.push_back(digit_char());
        case ($urandom_range(0, 3))
          1, 2: begin
            frame_q.push_back(ekrp_pkg::CharSlash);
            frame_q.push_back(digit_char());
          end
          3: begin
            frame_q.push_back(ekrp_pkg::CharSlash);
            frame_q.push_back(plain_byte());
          end
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) frame_q.push_back(dec_char());
      end
      6: begin
        case ($urandom_range(0, 5))
          0:       add_str("EB");
          1:       add_str("SA");
          2:       add_str("D2");
          3:       add_str("HY");
          4:       add_str("ea");
          default: add_str("AE");
        endcase
        frame_q.push_back(plain_byte());
        repeat ($urandom_range(0, 4)) frame_q.push_back(dec_char());
      end
      7: begin
        frame_q.push_back(plain_byte());
        frame_q.push_back(plain_byte());
        frame_q.push_back(plain_byte());
        repeat ($urandom_range(0, 4)) frame_q.push_back(hex_char());
      end
      8: begin
        // Record cut short inside its key or at the separator.
        n = $urandom_range(0, 2);
        if (n >= 1) frame_q.push_back("H");
        if (n >= 2) frame_q.push_back("Z");
      end
      default: repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
    endcase
    frame_q.push_back(($urandom_range(0, 3) == 0) ? ekrp_pkg::CharFill : ekrp_pkg::CharNewline);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_no_first_flag();
    // Straight out of reset the parser is already clear.
    frame_q.delete();
    add_str("SB 96\n");
    frame_q.push_back(ekrp_pkg::CharNull);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_mac_record();
    // Mixed-case hex, non-hex wrap, characters past the twelfth ignored.
    frame_q.delete();
    add_str("EA:0aF9Bc12gZ345");
    send_frame(1'b1, 1'b1);
    // A second EA clears the address; missing nibbles read as zero.
    frame_q.delete();
    add_str("EA=fFeE\nEA 12");
    frame_q.push_back(ekrp_pkg::CharFill);
    frame_q.push_back(ekrp_pkg::CharFill);
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_decimal_records();
    frame_q.delete();
    add_str("SB 1152\nD1 4096\nHZ 133/4\nXY 77\n");
    frame_q.push_back(ekrp_pkg::CharNull);
    send_frame(1'b1, 1'b0);
    frame_q.delete();
    add_str("HZ 50/0\nD1 99999999999");
    send_frame(1'b1, 1'b1);
    frame_q.delete();
    add_str("HZ /5");
    send_frame(1'b1, 1'b1);
    frame_q.delete();
    add_str("HZ 51/7xx\n");
    frame_q.push_back(ekrp_pkg::CharFill);
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_short_records();
    frame_q.delete();
    add_str("E\nEA\nD1 \nSB\nHZ 77/");
    send_frame(1'b1, 1'b1);
  endtask

  task automatic test_table_end_rule();
    // A null inside a value is a digit; a newline after a newline ends an empty record, not the table.
    frame_q.delete();
    add_str("SB 1");
    frame_q.push_back(ekrp_pkg::CharNull);
    add_str("2\n\nX\n");
    frame_q.push_back(ekrp_pkg::CharNull);
    add_str("SB 5");
    send_frame(1'b1, 1'b1);
    // A one-byte buffer, first and last together.
    frame_q.delete();
    add_str("D");
    send_frame(1'b1, 1'b1);
  endtask

  task automatic test_output_backpressure();
    wait_results_drained();
    sink_hold_req = LongHold;
    for (int k = 0; k < 6; k++) begin
      frame_q.delete();
      add_str($sformatf("SB %0d\n", 7 * k + 3));
      frame_q.push_back(ekrp_pkg::CharNull);
      send_frame(1'b1, 1'b0);
    end
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    src_random  = 1'b0;
    sink_random = 1'b0;
    frame_q.delete();
    add_str("HZ 200/3\nEA 0123456789ab\n");
    frame_q.push_back(ekrp_pkg::CharNull);
    send_frame(1'b1, 1'b0);
    frame_q.delete();
    add_str("HZ 99/9\nD1 512");
    send_frame(1'b1, 1'b1);
    frame_q.delete();
    add_str("SB 384\n");
    send_frame(1'b1, 1'b1);
    src_random  = 1'b1;
    sink_random = 1'b1;
  endtask

  task automatic test_random_frames();
    int byte_cnt;
    bit mark_last;
    byte_cnt = 0;
    while (byte_cnt < RandomBytes) begin
      frame_q.delete();
      repeat ($urandom_range(1, 3)) add_random_record();
      mark_last = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          frame_q.push_back(($urandom_range(0, 1) != 0) ? ekrp_pkg::CharNull
                                                         : ekrp_pkg::CharFill);
          repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
          mark_last = 1'($urandom_range(0, 1));
        end
        5, 6, 7: void'(frame_q.pop_back());
        8:       ;
        default: mark_last = 1'b0;
      endcase
      byte_cnt += frame_q.size();
      send_frame(1'b1, mark_last);
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_first_flag();
    test_mac_record();
    test_decimal_records();
    test_short_records();
    test_table_end_rule();
    test_output_backpressure();
    test_back_to_back();
    test_random_frames();

    wait_results_drained();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
